// ----- sv/sibc_pkg.sv -----
// Shared types and constants for the challenge sampler.
package sibc_pkg;

    localparam int FIELD_W    = 8;
    localparam int TAU_W      = 7;
    localparam int TAU_MAX    = 64;
    localparam int TAU_RESET  = 39;
    localparam int SIGN_BYTES = 8;
    localparam int SIGN_W     = 64;
    localparam int CNT_W      = 4;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_FEED  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] COEFF_ZERO = 2'b00;
    localparam logic [1:0] COEFF_POS  = 2'b01;
    localparam logic [1:0] COEFF_NEG  = 2'b11;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] stream_byte;
        logic [FIELD_W-1:0] coeff_index;
    } sibc_req_t;

    typedef struct packed {
        logic signed [1:0] coeff_value;
        logic              byte_accepted;
        logic              challenge_done;
    } sibc_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WRB
    } sibc_state_t;

endpackage

// ----- sv/sibc_coeff_mem.sv -----
// Coefficient memory: one write port, one registered read port.
module sibc_coeff_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/sample_in_ball_challenge_unit.sv -----
// Top level of the challenge sampler: control, sign word and coefficient store.
// Flow: an accepted request is registered, executed in ST_EXEC and its result registered;
// a placement also passes through ST_WRB. A new request is taken only while idle. A placement
// does one read and two writes on the coefficient memory, whose single write port takes both.
// Reset: control cleared, tau = 39, all coefficients read zero at once (valid bits).
// Results are shown for one cycle under result_valid; the receiver cannot stall.
module sample_in_ball_challenge_unit
    import sibc_pkg::*;
#(
    parameter int POLY_LEN = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sibc_req_t        request,
    output logic             result_valid,
    output sibc_rsp_t        result,
    input  logic             cfg_we,
    input  logic [TAU_W-1:0] cfg_wdata
);

    localparam int IW = $clog2(POLY_LEN);
    localparam int PW = $clog2(POLY_LEN + 1);
    localparam int CW = (PW > FIELD_W) ? PW : FIELD_W + 1;

    sibc_state_t         state_reg, state_next;
    sibc_req_t           req_reg, req_next;
    logic [TAU_W-1:0]    tau_reg, tau_next;
    logic [SIGN_W-1:0]   sign_reg, sign_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                done_reg, done_next;
    logic [POLY_LEN-1:0] valid_reg, valid_next;
    logic                out_valid_reg, out_valid_next;
    sibc_rsp_t           out_reg, out_next;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [1:0]          mem_wdata;
    logic [IW-1:0]       mem_raddr;
    logic [1:0]          mem_rdata;
    logic [1:0]          rd_coeff;
    logic [TAU_W-1:0]    tau_eff;
    logic [IW-1:0]       byte_idx;
    logic [IW-1:0]       read_idx;
    logic [IW-1:0]       pos_idx;
    logic                accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign mem_raddr = (request.func == FUNC_READ) ? request.coeff_index[IW-1:0]
                                                   : request.stream_byte[IW-1:0];
    assign byte_idx  = req_reg.stream_byte[IW-1:0];
    assign read_idx  = req_reg.coeff_index[IW-1:0];
    assign pos_idx   = pos_reg[IW-1:0];

    always_comb
    begin
        if (tau_reg == '0)
        begin
            tau_eff = TAU_W'(1);
        end
        else if (tau_reg > TAU_W'(TAU_MAX))
        begin
            tau_eff = TAU_W'(TAU_MAX);
        end
        else
        begin
            tau_eff = tau_reg;
        end
    end

    sibc_coeff_mem #(
        .DEPTH (POLY_LEN),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tau_reg       <= TAU_W'(TAU_RESET);
            sign_reg      <= '0;
            cnt_reg       <= '0;
            pos_reg       <= PW'(POLY_LEN - TAU_RESET);
            done_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tau_reg       <= tau_next;
            sign_reg      <= sign_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        tau_next       = cfg_we ? cfg_wdata : tau_reg;
        sign_next      = sign_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        valid_next     = valid_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_idx;
        mem_wdata      = COEFF_ZERO;
        rd_coeff       = COEFF_ZERO;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = request;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next                    = ST_IDLE;
                out_valid_next                = 1'b1;
                out_next.coeff_value          = COEFF_ZERO;
                out_next.byte_accepted        = 1'b0;
                out_next.challenge_done       = done_reg;
                case (req_reg.func)
                    FUNC_START:
                    begin
                        valid_next              = '0;
                        sign_next               = '0;
                        cnt_next                = '0;
                        pos_next                = PW'(POLY_LEN) - PW'(tau_eff);
                        done_next               = 1'b0;
                        out_next.challenge_done = 1'b0;
                    end
                    FUNC_FEED:
                    begin
                        if (!done_reg)
                        begin
                            if (cnt_reg < CNT_W'(SIGN_BYTES))
                            begin
                                // little-endian: first byte ends up in the low bits
                                sign_next = {req_reg.stream_byte,
                                             sign_reg[SIGN_W-1:FIELD_W]};
                                cnt_next  = cnt_reg + CNT_W'(1);
                                out_next.byte_accepted = 1'b1;
                            end
                            else if (CW'(req_reg.stream_byte) <= CW'(pos_reg) &&
                                     CW'(pos_reg) < CW'(POLY_LEN))
                            begin
                                if (valid_reg[byte_idx])
                                begin
                                    rd_coeff = mem_rdata;
                                end
                                mem_we              = 1'b1;
                                mem_waddr           = pos_idx;
                                mem_wdata           = rd_coeff;
                                valid_next[pos_idx] = 1'b1;
                                out_valid_next      = 1'b0;
                                state_next          = ST_WRB;
                            end
                        end
                    end
                    FUNC_READ:
                    begin
                        if (CW'(req_reg.coeff_index) < CW'(POLY_LEN) &&
                            valid_reg[read_idx])
                        begin
                            out_next.coeff_value = mem_rdata;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_WRB:
            begin
                mem_we               = 1'b1;
                mem_waddr            = byte_idx;
                mem_wdata            = sign_reg[0] ? COEFF_NEG : COEFF_POS;
                valid_next[byte_idx] = 1'b1;
                sign_next            = sign_reg >> 1;
                pos_next             = pos_reg + PW'(1);
                if (pos_reg + PW'(1) == PW'(POLY_LEN))
                begin
                    done_next = 1'b1;
                end
                out_valid_next          = 1'b1;
                out_next.coeff_value    = COEFF_ZERO;
                out_next.byte_accepted  = 1'b1;
                out_next.challenge_done = (pos_reg + PW'(1) == PW'(POLY_LEN));
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg != ST_IDLE))
        else $error("result without work in progress");

    a_place_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRB) |=> (result_valid && result.byte_accepted))
        else $error("placement did not report acceptance");

    a_coeff_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.coeff_value != 2'sb10))
        else $error("illegal coefficient code");

    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (pos_reg == PW'(POLY_LEN)))
        else $error("done without full placement");

endmodule
